// ----- sv/cges_pkg.sv -----
// package for the central gravity euler step block
// holds widths, reset values, command and state types shared by all modules
// no dependencies

package cges_pkg;

   localparam int DATA_W   = 32;
   localparam int STEP_W   = 24;
   localparam int STR_W    = 16;
   localparam int CSR_IDX_W = 2;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_X        = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_Y        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_STRENGTH = 2'd2;

   // item operation codes
   localparam logic OPER_STEP = 1'b0;
   localparam logic OPER_LOAD = 1'b1;

   // reset values
   localparam logic signed [DATA_W-1:0] RST_SOURCE_X   = 32'sd52428800;
   localparam logic signed [DATA_W-1:0] RST_SOURCE_Y   = 32'sd32768000;
   localparam logic [STR_W-1:0]         RST_STRENGTH   = 16'd6500;
   localparam logic signed [DATA_W-1:0] RST_POS_X      = 32'sd65536000;
   localparam logic signed [DATA_W-1:0] RST_POS_Y      = 32'sd32768000;
   localparam logic signed [DATA_W-1:0] RST_VEL_X      = 32'sd0;
   localparam logic signed [DATA_W-1:0] RST_VEL_Y      = -32'sd373613;

   // iteration counts (loaded as count minus one)
   localparam logic [5:0] SQRT_ITERS_M1 = 6'd31;
   localparam logic [5:0] Q1_ITERS_M1   = 6'd47;
   localparam logic [5:0] MAG_ITERS_M1  = 6'd63;
   localparam logic [5:0] U_ITERS_M1    = 6'd48;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_START,
      OP_SQ_X,
      OP_SQ_Y,
      OP_SQRT_INIT,
      OP_SQRT_STEP,
      OP_ROOT,
      OP_Q1_INIT,
      OP_DIV_STEP,
      OP_MAG_INIT,
      OP_MAG_SAT,
      OP_U_INIT,
      OP_MUL_LO,
      OP_MUL_HI,
      OP_ACC_SAT,
      OP_VEL_MUL,
      OP_VEL_UPD,
      OP_POS_MUL,
      OP_POS_UPD,
      OP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      axis;
      logic      singular;
   } dp_cmd_type;

   typedef struct packed {
      logic r_zero;
      logic out_free;
   } dp_status_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_SQ_X,
      S_SQ_Y,
      S_SQRT_INIT,
      S_SQRT,
      S_ROOT,
      S_CHECK,
      S_DIV_Q1,
      S_MAG_INIT,
      S_DIV_MAG,
      S_MAG_SAT,
      S_U_INIT,
      S_DIV_U,
      S_MUL_LO,
      S_MUL_HI,
      S_ACC_SAT,
      S_VEL_MUL,
      S_VEL_UPD,
      S_POS_MUL,
      S_POS_UPD,
      S_DONE
   } ctrl_state_type;

endpackage

// ----- sv/cges_req_if.sv -----
// request channel interface: valid/ready and the item payload
// depends on cges_pkg

interface cges_req_if;
   logic                                valid;
   logic                                ready;
   logic                                operation;
   logic [cges_pkg::STEP_W-1:0]         time_step;
   logic signed [cges_pkg::DATA_W-1:0]  load_pos_x;
   logic signed [cges_pkg::DATA_W-1:0]  load_pos_y;
   logic signed [cges_pkg::DATA_W-1:0]  load_vel_x;
   logic signed [cges_pkg::DATA_W-1:0]  load_vel_y;

   modport source (output valid, operation, time_step, load_pos_x, load_pos_y,
                   load_vel_x, load_vel_y, input ready);
   modport sink (input valid, operation, time_step, load_pos_x, load_pos_y,
                 load_vel_x, load_vel_y, output ready);
endinterface

// ----- sv/cges_rsp_if.sv -----
// response channel interface: valid/ready and the result payload
// depends on cges_pkg

interface cges_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [cges_pkg::DATA_W-1:0]  out_pos_x;
   logic signed [cges_pkg::DATA_W-1:0]  out_pos_y;
   logic signed [cges_pkg::DATA_W-1:0]  out_vel_x;
   logic signed [cges_pkg::DATA_W-1:0]  out_vel_y;
   logic                                singular;

   modport source (output valid, out_pos_x, out_pos_y, out_vel_x, out_vel_y, singular,
                   input ready);
   modport sink (input valid, out_pos_x, out_pos_y, out_vel_x, out_vel_y, singular,
                 output ready);
endinterface

// ----- sv/central_gravity_euler_step.sv -----
// one particle under inverse-square gravity, semi-implicit euler step
// top level: joins cges_ctrl and cges_dp; depends on cges_pkg and the channel interfaces
//
// usage:
//   req_bus carries items: operation 0 steps by time_step, operation 1 loads
//   position and velocity. rsp_bus carries one result per item: the state after
//   the item and the singular flag. a transfer happens when valid and ready are high.
//   csr_we/csr_index/csr_wdata write source_x (0), source_y (1), source_strength (2);
//   write only while no item is in flight.
// sequencing:
//   a load item passes from the transfer through the done state into the result
//   register; the next item can be taken once the sequencer is back in idle.
//   a step item runs a bit-serial square root, then four one-bit-per-cycle
//   divisions on the one shared divider, plus short multiply and update steps;
//   when the distance is zero the divisions and updates are skipped, the square
//   root still runs.
//   one item is worked on at a time; req ready is high only when the sequencer
//   is free.
// reset: particle state and source registers return to their default values,
//   the result register empties.
// stall: a held result stays on rsp_bus; the next item can be taken meanwhile
//   and its result waits in the sequencer until the register frees.

module central_gravity_euler_step (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [cges_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cges_pkg::DATA_W-1:0]        csr_wdata,
   cges_req_if.sink                           req_bus,
   cges_rsp_if.source                         rsp_bus
);

   cges_pkg::dp_cmd_type    cmd;
   cges_pkg::dp_status_type status;
   logic                    req_ready;

   // sequencer
   cges_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_bus.valid),
      .req_operation (req_bus.operation),
      .req_ready     (req_ready),
      .status        (status),
      .cmd           (cmd)
   );

   assign req_bus.ready = req_ready;

   // arithmetic and state
   cges_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .in_time_step  (req_bus.time_step),
      .in_load_pos_x (req_bus.load_pos_x),
      .in_load_pos_y (req_bus.load_pos_y),
      .in_load_vel_x (req_bus.load_vel_x),
      .in_load_vel_y (req_bus.load_vel_y),
      .cmd           (cmd),
      .status        (status),
      .rsp           (rsp_bus)
   );

endmodule

// ----- sv/cges_dp.sv -----
// datapath: config registers, particle state, shared multiplier,
// bit-serial square root and divider, output register
// depends on cges_pkg and cges_rsp_if

module cges_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [cges_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [cges_pkg::DATA_W-1:0]          csr_wdata,
   input  logic [cges_pkg::STEP_W-1:0]          in_time_step,
   input  logic signed [cges_pkg::DATA_W-1:0]   in_load_pos_x,
   input  logic signed [cges_pkg::DATA_W-1:0]   in_load_pos_y,
   input  logic signed [cges_pkg::DATA_W-1:0]   in_load_vel_x,
   input  logic signed [cges_pkg::DATA_W-1:0]   in_load_vel_y,
   input  cges_pkg::dp_cmd_type                 cmd,
   output cges_pkg::dp_status_type              status,
   cges_rsp_if.source                           rsp
);

   // config and particle state
   logic signed [31:0] src_x_ff, src_y_ff;
   logic [15:0]        strength_ff;
   logic signed [31:0] pos_x_ff, pos_y_ff, vel_x_ff, vel_y_ff;

   // working registers
   logic [23:0] t_ff;
   logic [32:0] mx_ff, my_ff;
   logic        neg_x_ff, neg_y_ff, half_ff;
   logic [63:0] acc_ff;
   logic [31:0] root_ff;
   logic [33:0] srem_ff;
   logic [32:0] r_ff;
   logic [63:0] dvd_ff;
   logic [32:0] drem_ff;
   logic [45:0] mag_ff;
   logic [31:0] am_ff;

   // output register
   logic               out_valid_ff;
   logic signed [31:0] out_pos_x_ff, out_pos_y_ff, out_vel_x_ff, out_vel_y_ff;
   logic               out_sing_ff;

   // saturate a 34-bit signed sum to 32 bits
   function automatic logic [31:0] sat34(input logic [33:0] s);
      logic [31:0] r;
      if (!s[33] && (s[32] || s[31])) begin
         r = 32'h7FFF_FFFF;
      end else if (s[33] && !(s[32] && s[31])) begin
         r = 32'h8000_0000;
      end else begin
         r = s[31:0];
      end
      return r;
   endfunction

   // offsets to the source
   logic [32:0] dx, dy, ax_mag, ay_mag;
   assign dx = {src_x_ff[31], src_x_ff} - {pos_x_ff[31], pos_x_ff};
   assign dy = {src_y_ff[31], src_y_ff} - {pos_y_ff[31], pos_y_ff};
   assign ax_mag = dx[32] ? (33'd0 - dx) : dx;
   assign ay_mag = dy[32] ? (33'd0 - dy) : dy;

   // per-axis selection
   logic [32:0]        cur_m;
   logic               cur_neg;
   logic signed [31:0] cur_v, cur_p;
   assign cur_m   = cmd.axis ? my_ff : mx_ff;
   assign cur_neg = cmd.axis ? neg_y_ff : neg_x_ff;
   assign cur_v   = cmd.axis ? vel_y_ff : vel_x_ff;
   assign cur_p   = cmd.axis ? pos_y_ff : pos_x_ff;

   // shared 32x32 multiplier
   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;
   always_comb begin
      case (cmd.op)
         cges_pkg::OP_SQ_X: begin
            mul_a = half_ff ? mx_ff[32:1] : mx_ff[31:0];
            mul_b = mul_a;
         end
         cges_pkg::OP_SQ_Y: begin
            mul_a = half_ff ? my_ff[32:1] : my_ff[31:0];
            mul_b = mul_a;
         end
         cges_pkg::OP_MUL_LO: begin
            mul_a = mag_ff[31:0];
            mul_b = dvd_ff[31:0];
         end
         cges_pkg::OP_MUL_HI: begin
            mul_a = {18'd0, mag_ff[45:32]};
            mul_b = dvd_ff[31:0];
         end
         cges_pkg::OP_VEL_MUL: begin
            mul_a = am_ff;
            mul_b = {8'd0, t_ff};
         end
         cges_pkg::OP_POS_MUL: begin
            mul_a = cur_v[31] ? (32'd0 - cur_v) : cur_v;
            mul_b = {8'd0, t_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign prod = mul_a * mul_b;

   // square root step (two radicand bits per cycle)
   logic [35:0] sq_rem_t, sq_trial;
   logic        sq_take;
   assign sq_rem_t = {srem_ff, acc_ff[63:62]};
   assign sq_trial = {2'b00, root_ff, 2'b01};
   assign sq_take  = (sq_rem_t >= sq_trial);

   // restoring divide step (one quotient bit per cycle)
   logic [33:0] dv_rem_t, dv_diff;
   logic        dv_take;
   assign dv_rem_t = {drem_ff, dvd_ff[63]};
   assign dv_diff  = dv_rem_t - {1'b0, r_ff};
   assign dv_take  = (dv_rem_t >= {1'b0, r_ff});

   // acceleration magnitude saturation
   logic [47:0] a48;
   assign a48 = acc_ff[63:16];

   // signed update of velocity or position by the scaled delta
   logic [31:0] delta;
   logic        upd_neg;
   logic [33:0] upd_sum;
   logic [31:0] upd_sat;
   assign delta   = acc_ff[55:24];
   assign upd_neg = (cmd.op == cges_pkg::OP_VEL_UPD) ? cur_neg : cur_v[31];
   always_comb begin
      if (cmd.op == cges_pkg::OP_VEL_UPD) begin
         upd_sum = {{2{cur_v[31]}}, cur_v};
      end else begin
         upd_sum = {{2{cur_p[31]}}, cur_p};
      end
      if (upd_neg) begin
         upd_sum = upd_sum - {2'b00, delta};
      end else begin
         upd_sum = upd_sum + {2'b00, delta};
      end
      upd_sat = sat34(upd_sum);
   end

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         src_x_ff    <= cges_pkg::RST_SOURCE_X;
         src_y_ff    <= cges_pkg::RST_SOURCE_Y;
         strength_ff <= cges_pkg::RST_STRENGTH;
      end else if (csr_we) begin
         case (csr_index)
            cges_pkg::CSR_SOURCE_X:        src_x_ff    <= csr_wdata;
            cges_pkg::CSR_SOURCE_Y:        src_y_ff    <= csr_wdata;
            cges_pkg::CSR_SOURCE_STRENGTH: strength_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // particle state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= cges_pkg::RST_POS_X;
         pos_y_ff <= cges_pkg::RST_POS_Y;
         vel_x_ff <= cges_pkg::RST_VEL_X;
         vel_y_ff <= cges_pkg::RST_VEL_Y;
      end else begin
         case (cmd.op)
            cges_pkg::OP_LOAD: begin
               pos_x_ff <= in_load_pos_x;
               pos_y_ff <= in_load_pos_y;
               vel_x_ff <= in_load_vel_x;
               vel_y_ff <= in_load_vel_y;
            end
            cges_pkg::OP_VEL_UPD: begin
               if (cmd.axis) vel_y_ff <= upd_sat;
               else vel_x_ff <= upd_sat;
            end
            cges_pkg::OP_POS_UPD: begin
               if (cmd.axis) pos_y_ff <= upd_sat;
               else pos_x_ff <= upd_sat;
            end
            default: ;
         endcase
      end
   end

   // working registers of the step computation
   always_ff @(posedge clock) begin
      case (cmd.op)
         cges_pkg::OP_START: begin
            t_ff     <= in_time_step;
            mx_ff    <= ax_mag;
            my_ff    <= ay_mag;
            neg_x_ff <= dx[32];
            neg_y_ff <= dy[32];
            half_ff  <= ax_mag[32] | ax_mag[31] | ay_mag[32] | ay_mag[31];
         end
         cges_pkg::OP_SQ_X: acc_ff <= prod;
         cges_pkg::OP_SQ_Y: acc_ff <= acc_ff + prod;
         cges_pkg::OP_SQRT_INIT: begin
            root_ff <= '0;
            srem_ff <= '0;
         end
         cges_pkg::OP_SQRT_STEP: begin
            acc_ff <= {acc_ff[61:0], 2'b00};
            if (sq_take) begin
               srem_ff <= 34'(sq_rem_t - sq_trial);
               root_ff <= {root_ff[30:0], 1'b1};
            end else begin
               srem_ff <= sq_rem_t[33:0];
               root_ff <= {root_ff[30:0], 1'b0};
            end
         end
         cges_pkg::OP_ROOT: r_ff <= half_ff ? {root_ff, 1'b0} : {1'b0, root_ff};
         cges_pkg::OP_Q1_INIT: begin
            dvd_ff  <= {strength_ff, 48'd0};
            drem_ff <= '0;
         end
         cges_pkg::OP_DIV_STEP: begin
            if (dv_take) begin
               drem_ff <= dv_diff[32:0];
               dvd_ff  <= {dvd_ff[62:0], 1'b1};
            end else begin
               drem_ff <= dv_rem_t[32:0];
               dvd_ff  <= {dvd_ff[62:0], 1'b0};
            end
         end
         cges_pkg::OP_MAG_INIT: begin
            dvd_ff  <= {dvd_ff[47:0], 16'd0};
            drem_ff <= '0;
         end
         cges_pkg::OP_MAG_SAT: begin
            if (dvd_ff > 64'h0000_2000_0000_0000) mag_ff <= 46'h2000_0000_0000;
            else mag_ff <= dvd_ff[45:0];
         end
         cges_pkg::OP_U_INIT: begin
            dvd_ff  <= {cur_m, 31'd0};
            drem_ff <= '0;
         end
         cges_pkg::OP_MUL_LO: acc_ff <= prod;
         cges_pkg::OP_MUL_HI: acc_ff <= acc_ff + {prod[31:0], 32'd0};
         cges_pkg::OP_ACC_SAT: begin
            if (cur_neg) begin
               am_ff <= (a48 > 48'h0000_8000_0000) ? 32'h8000_0000 : a48[31:0];
            end else begin
               am_ff <= (a48 > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : a48[31:0];
            end
         end
         cges_pkg::OP_VEL_MUL: acc_ff <= prod;
         cges_pkg::OP_POS_MUL: acc_ff <= prod;
         default: ;
      endcase
   end

   // output register, refilled while the receiver takes the old transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.op == cges_pkg::OP_OUT) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == cges_pkg::OP_OUT) begin
         out_pos_x_ff <= pos_x_ff;
         out_pos_y_ff <= pos_y_ff;
         out_vel_x_ff <= vel_x_ff;
         out_vel_y_ff <= vel_y_ff;
         out_sing_ff  <= cmd.singular;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.out_pos_x = out_pos_x_ff;
   assign rsp.out_pos_y = out_pos_y_ff;
   assign rsp.out_vel_x = out_vel_x_ff;
   assign rsp.out_vel_y = out_vel_y_ff;
   assign rsp.singular  = out_sing_ff;

   assign status.r_zero   = (r_ff == 33'd0);
   assign status.out_free = !out_valid_ff || rsp.ready;

   // output never overwritten while a transfer is pending
   a_out_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == cges_pkg::OP_OUT) |-> (!out_valid_ff || rsp.ready))
      else $error("output register overwritten while pending");

   // a divide step never sees a zero divisor
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == cges_pkg::OP_DIV_STEP) |-> (r_ff != 33'd0))
      else $error("divide step with zero divisor");

   // the remainder of the divider stays below the divisor
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      ($past(cmd.op) == cges_pkg::OP_DIV_STEP) |-> ({1'b0, drem_ff} < {1'b0, r_ff}))
      else $error("divider remainder out of range");

endmodule

// ----- sv/cges_ctrl.sv -----
// controller: sequences one item through the datapath
// depends on cges_pkg

module cges_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_operation,
   output logic                     req_ready,
   input  cges_pkg::dp_status_type  status,
   output cges_pkg::dp_cmd_type     cmd
);

   cges_pkg::ctrl_state_type state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic       axis_ff, axis_in;
   logic       sing_ff, sing_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cges_pkg::S_IDLE;
         cnt_ff   <= '0;
         axis_ff  <= 1'b0;
         sing_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         axis_ff  <= axis_in;
         sing_ff  <= sing_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      axis_in      = axis_ff;
      sing_in      = sing_ff;
      req_ready    = 1'b0;
      cmd.op       = cges_pkg::OP_NONE;
      cmd.axis     = axis_ff;
      cmd.singular = sing_ff;
      case (state_ff)
         cges_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               sing_in = 1'b0;
               axis_in = 1'b0;
               if (req_operation == cges_pkg::OPER_LOAD) begin
                  cmd.op   = cges_pkg::OP_LOAD;
                  state_in = cges_pkg::S_DONE;
               end else begin
                  cmd.op   = cges_pkg::OP_START;
                  state_in = cges_pkg::S_SQ_X;
               end
            end
         end
         cges_pkg::S_SQ_X: begin
            cmd.op   = cges_pkg::OP_SQ_X;
            state_in = cges_pkg::S_SQ_Y;
         end
         cges_pkg::S_SQ_Y: begin
            cmd.op   = cges_pkg::OP_SQ_Y;
            state_in = cges_pkg::S_SQRT_INIT;
         end
         cges_pkg::S_SQRT_INIT: begin
            cmd.op   = cges_pkg::OP_SQRT_INIT;
            cnt_in   = cges_pkg::SQRT_ITERS_M1;
            state_in = cges_pkg::S_SQRT;
         end
         cges_pkg::S_SQRT: begin
            cmd.op = cges_pkg::OP_SQRT_STEP;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) state_in = cges_pkg::S_ROOT;
         end
         cges_pkg::S_ROOT: begin
            cmd.op   = cges_pkg::OP_ROOT;
            state_in = cges_pkg::S_CHECK;
         end
         cges_pkg::S_CHECK: begin
            if (status.r_zero) begin
               sing_in  = 1'b1;
               state_in = cges_pkg::S_DONE;
            end else begin
               cmd.op   = cges_pkg::OP_Q1_INIT;
               cnt_in   = cges_pkg::Q1_ITERS_M1;
               state_in = cges_pkg::S_DIV_Q1;
            end
         end
         cges_pkg::S_DIV_Q1: begin
            cmd.op = cges_pkg::OP_DIV_STEP;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) state_in = cges_pkg::S_MAG_INIT;
         end
         cges_pkg::S_MAG_INIT: begin
            cmd.op   = cges_pkg::OP_MAG_INIT;
            cnt_in   = cges_pkg::MAG_ITERS_M1;
            state_in = cges_pkg::S_DIV_MAG;
         end
         cges_pkg::S_DIV_MAG: begin
            cmd.op = cges_pkg::OP_DIV_STEP;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) state_in = cges_pkg::S_MAG_SAT;
         end
         cges_pkg::S_MAG_SAT: begin
            cmd.op   = cges_pkg::OP_MAG_SAT;
            state_in = cges_pkg::S_U_INIT;
         end
         cges_pkg::S_U_INIT: begin
            cmd.op   = cges_pkg::OP_U_INIT;
            cnt_in   = cges_pkg::U_ITERS_M1;
            state_in = cges_pkg::S_DIV_U;
         end
         cges_pkg::S_DIV_U: begin
            cmd.op = cges_pkg::OP_DIV_STEP;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) state_in = cges_pkg::S_MUL_LO;
         end
         cges_pkg::S_MUL_LO: begin
            cmd.op   = cges_pkg::OP_MUL_LO;
            state_in = cges_pkg::S_MUL_HI;
         end
         cges_pkg::S_MUL_HI: begin
            cmd.op   = cges_pkg::OP_MUL_HI;
            state_in = cges_pkg::S_ACC_SAT;
         end
         cges_pkg::S_ACC_SAT: begin
            cmd.op   = cges_pkg::OP_ACC_SAT;
            state_in = cges_pkg::S_VEL_MUL;
         end
         cges_pkg::S_VEL_MUL: begin
            cmd.op   = cges_pkg::OP_VEL_MUL;
            state_in = cges_pkg::S_VEL_UPD;
         end
         cges_pkg::S_VEL_UPD: begin
            cmd.op   = cges_pkg::OP_VEL_UPD;
            state_in = cges_pkg::S_POS_MUL;
         end
         cges_pkg::S_POS_MUL: begin
            cmd.op   = cges_pkg::OP_POS_MUL;
            state_in = cges_pkg::S_POS_UPD;
         end
         cges_pkg::S_POS_UPD: begin
            cmd.op = cges_pkg::OP_POS_UPD;
            if (axis_ff) begin
               state_in = cges_pkg::S_DONE;
            end else begin
               axis_in  = 1'b1;
               state_in = cges_pkg::S_U_INIT;
            end
         end
         cges_pkg::S_DONE: begin
            if (status.out_free) begin
               cmd.op   = cges_pkg::OP_OUT;
               state_in = cges_pkg::S_IDLE;
            end
         end
         default: state_in = cges_pkg::S_IDLE;
      endcase
   end

   // a load transfer goes straight to the result
   a_load_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cges_pkg::S_IDLE && req_valid && req_operation == cges_pkg::OPER_LOAD)
      |=> (state_ff == cges_pkg::S_DONE && !sing_ff))
      else $error("load did not go to result");

   // zero distance skips the update and flags singular
   a_singular: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cges_pkg::S_CHECK && status.r_zero)
      |=> (state_ff == cges_pkg::S_DONE && sing_ff))
      else $error("singular step not flagged");

   // the second axis always ends the step
   a_axis_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cges_pkg::S_POS_UPD && axis_ff) |=> (state_ff == cges_pkg::S_DONE))
      else $error("step did not finish after second axis");

endmodule

// ----- sim/central_gravity_euler_step_tb.sv -----
// testbench for central_gravity_euler_step: drives load and step items, checks every
// result against an in-bench fixed-point predictor of the gravity euler step
// depends on cges_pkg, cges_req_if, cges_rsp_if and the rtl top level
`timescale 1ns / 1ps

module central_gravity_euler_step_tb;

   localparam int FRAC = 16;
   localparam int STEP_FRAC = 24;
   localparam longint MAX32 = 64'sd2147483647;
   localparam longint MIN32 = -64'sd2147483648;

   typedef struct packed {
      logic                        oper;
      logic [cges_pkg::STEP_W-1:0] dt;
      logic [31:0]                 px, py, vx, vy;
   } grav_item_type;

   typedef struct packed {
      logic [31:0] px, py, vx, vy;
      logic        sing;
   } grav_state_type;

   typedef struct packed {
      grav_item_type  item;
      logic           known;
      grav_state_type res;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [cges_pkg::CSR_IDX_W-1:0] csr_index = cges_pkg::CSR_SOURCE_X;
   logic [cges_pkg::DATA_W-1:0] csr_wdata = '0;

   cges_req_if req_bus ();
   cges_rsp_if rsp_bus ();

   central_gravity_euler_step uut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source)
   );

   always #5 clock = ~clock;

   // predictor copy of the block's state and registers
   longint src_x, src_y, pos_x, pos_y, vel_x, vel_y;
   longint unsigned strength;

   grav_state_type expected_states[$];
   stim_row_type directed_rows[$];
   int fail_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_off_cycles = 0;
   logic all_sent = 1'b0;

   function automatic longint sat32(longint v);
      if (v > MAX32) return MAX32;
      if (v < MIN32) return MIN32;
      return v;
   endfunction

   function automatic longint unsigned magn(longint v);
      return v < 0 ? longint'(-v) : longint'(v);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint scale_by_dt(longint v, longint unsigned t);
      longint unsigned d;
      d = (magn(v) * t) >> STEP_FRAC;
      return v < 0 ? -longint'(d) : longint'(d);
   endfunction

   function automatic longint axis_accel(longint d, longint unsigned r, longint unsigned m);
      longint unsigned u, a;
      u = (magn(d) << FRAC) / r;
      a = (m * u) >> FRAC;
      if (a > 64'd2147483648) a = 64'd2147483648;
      return sat32(d < 0 ? -longint'(a) : longint'(a));
   endfunction

   function automatic void reset_model();
      src_x = cges_pkg::RST_SOURCE_X; src_y = cges_pkg::RST_SOURCE_Y;
      strength = cges_pkg::RST_STRENGTH;
      pos_x = cges_pkg::RST_POS_X; pos_y = cges_pkg::RST_POS_Y;
      vel_x = cges_pkg::RST_VEL_X; vel_y = cges_pkg::RST_VEL_Y;
   endfunction

   // advance the predictor by one item and return the resulting state
   function automatic grav_state_type predict_motion(grav_item_type it);
      grav_state_type s;
      longint dx, dy, ax, ay;
      longint unsigned mx, my, r, t, q1, m, cap;
      s.sing = 1'b0;
      if (it.oper == cges_pkg::OPER_LOAD) begin
         pos_x = longint'($signed(it.px)); pos_y = longint'($signed(it.py));
         vel_x = longint'($signed(it.vx)); vel_y = longint'($signed(it.vy));
      end else begin
         t = it.dt;
         dx = src_x - pos_x; dy = src_y - pos_y;
         mx = magn(dx); my = magn(dy);
         if (mx >= 64'h8000_0000 || my >= 64'h8000_0000) begin
            mx >>= 1; my >>= 1;
            r = int_sqrt(mx * mx + my * my) << 1;
         end else begin
            r = int_sqrt(mx * mx + my * my);
         end
         if (r == 0) begin
            s.sing = 1'b1;
         end else begin
            cap = 64'd1 << (61 - FRAC);
            q1 = (strength << (2 * FRAC)) / r;
            if (q1 >= (64'd1 << (64 - FRAC))) m = cap;
            else m = (q1 << FRAC) / r;
            if (m > cap) m = cap;
            ax = axis_accel(dx, r, m);
            ay = axis_accel(dy, r, m);
            vel_x = sat32(vel_x + scale_by_dt(ax, t));
            vel_y = sat32(vel_y + scale_by_dt(ay, t));
            pos_x = sat32(pos_x + scale_by_dt(vel_x, t));
            pos_y = sat32(pos_y + scale_by_dt(vel_y, t));
         end
      end
      s.px = pos_x[31:0]; s.py = pos_y[31:0]; s.vx = vel_x[31:0]; s.vy = vel_y[31:0];
      return s;
   endfunction

   function automatic grav_item_type make_load(longint px, longint py, longint vx,
                                               longint vy);
      grav_item_type it;
      it.oper = cges_pkg::OPER_LOAD; it.dt = 24'($urandom);
      it.px = px[31:0]; it.py = py[31:0]; it.vx = vx[31:0]; it.vy = vy[31:0];
      return it;
   endfunction

   function automatic grav_item_type make_step(logic [cges_pkg::STEP_W-1:0] dt);
      grav_item_type it;
      it.oper = cges_pkg::OPER_STEP; it.dt = dt;
      it.px = $urandom; it.py = $urandom; it.vx = $urandom; it.vy = $urandom;
      return it;
   endfunction

   function automatic void add_row(grav_item_type it, logic known, grav_state_type res);
      stim_row_type row;
      row.item = it; row.known = known; row.res = res;
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   function automatic grav_state_type st(longint px, longint py, longint vx, longint vy,
                                         logic sing);
      grav_state_type s;
      s.px = px[31:0]; s.py = py[31:0]; s.vx = vx[31:0]; s.vy = vy[31:0]; s.sing = sing;
      return s;
   endfunction

   // one item on the request channel, honoring the sender idle rate
   // valid stays high after the transfer until the next call or a drain decides
   task automatic send_item(grav_item_type it, logic known, grav_state_type res);
      grav_state_type p;
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.operation <= it.oper; req_bus.time_step <= it.dt;
      req_bus.load_pos_x <= it.px; req_bus.load_pos_y <= it.py;
      req_bus.load_vel_x <= it.vx; req_bus.load_vel_y <= it.vy;
      do @(posedge clock); while (!req_bus.ready);
      p = predict_motion(it);
      if (known && (p != res)) begin
         $error("table row disagrees with predictor");
         fail_count++;
      end
      expected_states.insert(expected_states.size(), known ? res : p);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [cges_pkg::CSR_IDX_W-1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == cges_pkg::CSR_SOURCE_X) src_x = longint'($signed(val));
      else if (idx == cges_pkg::CSR_SOURCE_Y) src_y = longint'($signed(val));
      else if (idx == cges_pkg::CSR_SOURCE_STRENGTH) strength = val[15:0];
   endtask

   // wait for the block to drain before a register write
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (expected_states.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
   endtask

   function automatic longint rand_coord();
      case ($urandom_range(3, 0))
         0: return longint'($signed($urandom));
         1: return longint'($signed(32'($urandom_range(2000, 0)) << 16));
         default: return longint'($urandom_range(1200, 200)) <<< 16;
      endcase
   endfunction

   // random phase: mostly orbits near the source, some wild loads
   task automatic random_phase(int n);
      grav_item_type it;
      grav_state_type none;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(9, 0) == 0)
            it = make_load(rand_coord(), rand_coord(), longint'($signed($urandom)) >>>
                           $urandom_range(16, 0), longint'($signed($urandom)) >>>
                           $urandom_range(16, 0));
         else
            it = make_step(24'($urandom_range(3, 0) == 0 ? $urandom :
                               $urandom_range(4095, 0)));
         send_item(it, 1'b0, none);
      end
   endtask

   // result checking, with receiver idling and the long hold-off
   always @(posedge clock) begin
      grav_state_type e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_states.size() == 0) begin
            $error("result with nothing expected");
            fail_count++;
         end else begin
            e = expected_states.pop_front();
            if (rsp_bus.out_pos_x !== e.px) begin
               $error("out_pos_x expected %h actual %h", e.px, rsp_bus.out_pos_x);
               fail_count++;
            end
            if (rsp_bus.out_pos_y !== e.py) begin
               $error("out_pos_y expected %h actual %h", e.py, rsp_bus.out_pos_y);
               fail_count++;
            end
            if (rsp_bus.out_vel_x !== e.vx) begin
               $error("out_vel_x expected %h actual %h", e.vx, rsp_bus.out_vel_x);
               fail_count++;
            end
            if (rsp_bus.out_vel_y !== e.vy) begin
               $error("out_vel_y expected %h actual %h", e.vy, rsp_bus.out_vel_y);
               fail_count++;
            end
            if (rsp_bus.singular !== e.sing) begin
               $error("singular expected %b actual %b", e.sing, rsp_bus.singular);
               fail_count++;
            end
         end
      end
   end

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_off_cycles--;
         end else begin
            rsp_bus.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
         end
      end
   end

   initial begin
      grav_state_type none;
      req_bus.valid = 1'b0; req_bus.operation = cges_pkg::OPER_STEP; req_bus.time_step = '0;
      req_bus.load_pos_x = '0; req_bus.load_pos_y = '0;
      req_bus.load_vel_x = '0; req_bus.load_vel_y = '0;
      reset_model();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table: reset state, extremes, singular, saturation
      add_row(make_step(24'd0), 1'b0, none);
      add_row(make_load(cges_pkg::RST_POS_X, cges_pkg::RST_POS_Y, cges_pkg::RST_VEL_X,
                        cges_pkg::RST_VEL_Y), 1'b1,
              st(cges_pkg::RST_POS_X, cges_pkg::RST_POS_Y, cges_pkg::RST_VEL_X,
                 cges_pkg::RST_VEL_Y, 1'b0));
      add_row(make_step(24'hFFFFFF), 1'b0, none);
      add_row(make_step(24'h000001), 1'b0, none);
      add_row(make_load(cges_pkg::RST_SOURCE_X, cges_pkg::RST_SOURCE_Y, 5, -7), 1'b1,
              st(cges_pkg::RST_SOURCE_X, cges_pkg::RST_SOURCE_Y, 5, -7, 1'b0));
      add_row(make_step(24'hFFFFFF), 1'b1,
              st(cges_pkg::RST_SOURCE_X, cges_pkg::RST_SOURCE_Y, 5, -7, 1'b1));
      add_row(make_load(MIN32, MIN32, MAX32, MIN32), 1'b1,
              st(MIN32, MIN32, MAX32, MIN32, 1'b0));
      add_row(make_step(24'hFFFFFF), 1'b0, none);
      add_row(make_load(MAX32, MAX32, MIN32, MAX32), 1'b1,
              st(MAX32, MAX32, MIN32, MAX32, 1'b0));
      add_row(make_step(24'h800000), 1'b0, none);
      add_row(make_load(cges_pkg::RST_SOURCE_X + 65536, cges_pkg::RST_SOURCE_Y, 0, 0), 1'b1,
              st(cges_pkg::RST_SOURCE_X + 65536, cges_pkg::RST_SOURCE_Y, 0, 0, 1'b0));
      add_row(make_step(24'hFFFFFF), 1'b0, none);
      add_row(make_load(cges_pkg::RST_SOURCE_X + 1, cges_pkg::RST_SOURCE_Y - 1, 0, 0), 1'b1,
              st(cges_pkg::RST_SOURCE_X + 1, cges_pkg::RST_SOURCE_Y - 1, 0, 0, 1'b0));
      add_row(make_step(24'hFFFFFF), 1'b0, none);
      add_row(make_step(24'h000000), 1'b0, none);
      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].known, directed_rows[i].res);

      // register extremes: strong source at far corner, zero strength, reset values
      drain();
      write_reg(cges_pkg::CSR_SOURCE_X, 32'h7FFF_FFFF);
      write_reg(cges_pkg::CSR_SOURCE_Y, 32'h8000_0000);
      write_reg(cges_pkg::CSR_SOURCE_STRENGTH, 32'h0000_FFFF);
      send_item(make_load(MIN32, MAX32, 0, 0), 1'b0, none);
      send_item(make_step(24'hFFFFFF), 1'b0, none);
      send_item(make_load(32'sh7FFF_FFF0, 32'sh8000_0010, 0, 0), 1'b0, none);
      send_item(make_step(24'hFFFFFF), 1'b0, none);
      drain();
      write_reg(cges_pkg::CSR_SOURCE_STRENGTH, 32'h0);
      send_item(make_step(24'hFFFFFF), 1'b0, none);
      drain();
      write_reg(cges_pkg::CSR_SOURCE_X, cges_pkg::RST_SOURCE_X);
      write_reg(cges_pkg::CSR_SOURCE_Y, cges_pkg::RST_SOURCE_Y);
      write_reg(cges_pkg::CSR_SOURCE_STRENGTH, 32'h0001_0000 | cges_pkg::RST_STRENGTH);
      send_item(make_load(cges_pkg::RST_POS_X, cges_pkg::RST_POS_Y, cges_pkg::RST_VEL_X,
                          cges_pkg::RST_VEL_Y), 1'b0, none);

      // receiver holds off while items keep coming
      hold_off_cycles = 1500;
      random_phase(10);

      // idle mixes and register settings across random phases
      send_idle_pct = 16; recv_idle_pct = 83;
      random_phase(470);
      drain();
      write_reg(cges_pkg::CSR_SOURCE_X, $urandom);
      write_reg(cges_pkg::CSR_SOURCE_Y, $urandom);
      write_reg(cges_pkg::CSR_SOURCE_STRENGTH, $urandom_range(65535, 0));
      send_idle_pct = 83; recv_idle_pct = 16;
      random_phase(470);
      drain();
      write_reg(cges_pkg::CSR_SOURCE_X, cges_pkg::RST_SOURCE_X);
      write_reg(cges_pkg::CSR_SOURCE_Y, cges_pkg::RST_SOURCE_Y);
      write_reg(cges_pkg::CSR_SOURCE_STRENGTH, $urandom_range(20000, 1));
      send_idle_pct = 0; recv_idle_pct = 0;
      random_phase(470);
      req_bus.valid <= 1'b0;
      all_sent = 1'b1;
   end

   // end of run
   initial begin
      wait (all_sent);
      while (expected_states.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (fail_count == 0)
         $display("central_gravity_euler_step: match");
      else
         $display("central_gravity_euler_step: mismatch");
      $finish;
   end

   initial begin
      #20ms;
      $display("central_gravity_euler_step: mismatch");
      $finish;
   end

endmodule

// ----- central_gravity_euler_step.f -----
sv/cges_pkg.sv
sv/cges_req_if.sv
sv/cges_rsp_if.sv
sv/cges_dp.sv
sv/cges_ctrl.sv
sv/central_gravity_euler_step.sv
sim/central_gravity_euler_step_tb.sv
